### sv/pfj_pkg.sv
`timescale 1ns / 1ps
package pfj_pkg;

  localparam int DataW       = 32;
  localparam int FracBitsDef = 20;
  localparam int WideW       = 64;
  localparam int SatW        = WideW + 2;
  localparam int SqrtSteps   = 32;
  localparam int TQuoW       = 32;

  typedef logic signed [DataW-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    word_t v_row_re;
    word_t v_row_im;
    word_t v_col_re;
    word_t v_col_im;
    word_t s_row_re;
    word_t s_row_im;
    word_t y_re;
    word_t y_im;
    logic  diagonal;
  } in_item_t;

  typedef struct packed {
    word_t dp_dtheta;
    word_t dq_dtheta;
    word_t dp_dvmag;
    word_t dq_dvmag;
    logic  fault;
  } out_item_t;

  // Operands carried along the front of the pipe
  typedef struct packed {
    word_t vi_re;
    word_t vi_im;
    word_t vs_re;
    word_t vs_im;
    word_t si_re;
    word_t si_im;
    word_t y_re;
    word_t y_im;
    logic  diag;
  } work_t;

  // Operands carried through the quotient divider
  typedef struct packed {
    word_t b_re;
    word_t b_im;
    word_t e_re;
    word_t e_im;
    word_t si_re;
    word_t si_im;
    logic  diag;
    logic  mag_zero;
    logic  ov_common;
    logic  ov_extra;
    logic  sgn_re;
    logic  sgn_im;
    logic  tov_re;
    logic  tov_im;
  } fin_t;

  typedef struct packed {
    word_t v;
    logic  ov;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SatW-1:0] x);
    sat_t r;
    logic [SatW-DataW:0] hi;
    hi = x[SatW-1:DataW-1];
    if ((hi == '0) || (hi == '1)) begin
      r.v  = x[DataW-1:0];
      r.ov = 1'b0;
    end else begin
      r.v  = x[SatW-1] ? WordMin : WordMax;
      r.ov = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] abs_word(input word_t x);
    return x[DataW-1] ? DataW'(-x) : DataW'(x);
  endfunction

endpackage

### sv/pfj_in_if.sv
`timescale 1ns / 1ps
interface pfj_in_if import pfj_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/pfj_out_if.sv
`timescale 1ns / 1ps
interface pfj_out_if import pfj_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/pfj_sqrt_cell.sv
`timescale 1ns / 1ps
module pfj_sqrt_cell import pfj_pkg::*; #(
  parameter int STEP  = 0,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [WideW-1:0] rem_i,
  input  logic [WideW-1:0] root_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [WideW-1:0] rem_o,
  output logic [WideW-1:0] root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam logic [WideW-1:0] Bit = WideW'(1) << (WideW - 2 - 2 * STEP);

  logic [WideW-1:0] trial;
  logic             take;
  logic             valid_q;
  logic [WideW-1:0] rem_q, root_q;
  logic [TAG_W-1:0] tag_q;

  assign trial = root_i + Bit;
  assign take  = rem_i >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // one root bit per cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= take ? rem_i - trial : rem_i;
      root_q <= take ? (root_i >> 1) + Bit : root_i >> 1;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign tag_o   = tag_q;

endmodule

### sv/pfj_div_cell.sv
`timescale 1ns / 1ps
module pfj_div_cell import pfj_pkg::*; #(
  parameter int STEP  = 0,
  parameter int REM_W = 64,
  parameter int QW    = 32,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DataW-1:0] div_i,
  input  logic [REM_W-1:0] rem_re_i,
  input  logic [REM_W-1:0] rem_im_i,
  input  logic [QW-1:0]    q_re_i,
  input  logic [QW-1:0]    q_im_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [DataW-1:0] div_o,
  output logic [REM_W-1:0] rem_re_o,
  output logic [REM_W-1:0] rem_im_o,
  output logic [QW-1:0]    q_re_o,
  output logic [QW-1:0]    q_im_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [REM_W-1:0] dsh;
  logic             take_re, take_im;
  logic             valid_q;
  logic [DataW-1:0] div_q;
  logic [REM_W-1:0] rem_re_q, rem_im_q;
  logic [QW-1:0]    q_re_q, q_im_q;
  logic [TAG_W-1:0] tag_q;

  assign dsh     = REM_W'(div_i) << STEP;
  assign take_re = rem_re_i >= dsh;
  assign take_im = rem_im_i >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // restoring step on both lanes, one quotient bit each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q    <= div_i;
      rem_re_q <= take_re ? rem_re_i - dsh : rem_re_i;
      rem_im_q <= take_im ? rem_im_i - dsh : rem_im_i;
      q_re_q   <= q_re_i | (QW'(take_re) << STEP);
      q_im_q   <= q_im_i | (QW'(take_im) << STEP);
      tag_q    <= tag_i;
    end
  end

  assign valid_o  = valid_q;
  assign div_o    = div_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign q_re_o   = q_re_q;
  assign q_im_o   = q_im_q;
  assign tag_o    = tag_q;

endmodule

### sv/pfj_cmul.sv
`timescale 1ns / 1ps
module pfj_cmul import pfj_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t a_re_i,
  input  word_t a_im_i,
  input  word_t b_re_i,
  input  word_t b_im_i,
  output word_t re_o,
  output word_t im_o,
  output logic  ov_o
);

  logic signed [WideW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [WideW-1:0] s_rr, s_ii, s_ri, s_ir;
  sat_t                    re_sat, im_sat;
  word_t                   re_q, im_q;
  logic                    ov_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q <= a_re_i * b_re_i;
      p_ii_q <= a_im_i * b_im_i;
      p_ri_q <= a_re_i * b_im_i;
      p_ir_q <= a_im_i * b_re_i;
    end
  end

  // floor the scaled products, then add and clamp
  always_comb begin
    s_rr   = p_rr_q >>> FRAC_BITS;
    s_ii   = p_ii_q >>> FRAC_BITS;
    s_ri   = p_ri_q >>> FRAC_BITS;
    s_ir   = p_ir_q >>> FRAC_BITS;
    re_sat = sat_word(SatW'(s_rr) - SatW'(s_ii));
    im_sat = sat_word(SatW'(s_ri) + SatW'(s_ir));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q <= re_sat.v;
      im_q <= im_sat.v;
      ov_q <= re_sat.ov | im_sat.ov;
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;
  assign ov_o = ov_q;

endmodule

### sv/power_flow_jacobian_entry.sv
`timescale 1ns / 1ps
// Polar Jacobian entry unit: one admittance entry in, four Jacobian parts and a fault out.
// Throughput: one transaction per cycle unless a held output stalls the pipe; every stage is a register.
// The magnitude chain (32 root cells) and the two divider chains set the depth.
// Reset: rst_ni clears all valid bits asynchronously; data registers are not reset.
module power_flow_jacobian_entry import pfj_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfj_in_if.sink    in_i,
  pfj_out_if.source out_o
);

  localparam int UQuoW = FRAC_BITS + 1;    // |u| <= 1.0
  localparam int URemW = DataW + UQuoW;
  localparam int TRemW = DataW + TQuoW;
  localparam int WorkW = $bits(work_t);
  localparam int FinW  = $bits(fin_t);

  // Global advance: the pipe moves unless a finished result would hit a held output.
  logic      en;
  logic      fin_valid;
  logic      out_valid_q;
  out_item_t out_data_q;
  out_item_t res;

  assign en         = !out_valid_q || out_o.ready || !fin_valid;
  assign in_i.ready = en;

  // ---------------- Stage 0: select the unit-vector source, square it ----------------
  work_t                   w_in;
  logic                    s0_valid_q;
  work_t                   s0_work_q;
  logic signed [WideW-1:0] s0_sqre_q, s0_sqim_q;

  always_comb begin
    w_in.vi_re = in_i.data.v_row_re;
    w_in.vi_im = in_i.data.v_row_im;
    w_in.vs_re = in_i.data.diagonal ? in_i.data.v_row_re : in_i.data.v_col_re;
    w_in.vs_im = in_i.data.diagonal ? in_i.data.v_row_im : in_i.data.v_col_im;
    w_in.si_re = in_i.data.s_row_re;
    w_in.si_im = in_i.data.s_row_im;
    w_in.y_re  = in_i.data.y_re;
    w_in.y_im  = in_i.data.y_im;
    w_in.diag  = in_i.data.diagonal;
  end

  // ---------------- Stage 1: sum of squares ----------------
  logic             s1_valid_q;
  work_t            s1_work_q;
  logic [WideW-1:0] s1_n_q;

  // ---------------- Magnitude: one root bit per cell ----------------
  logic             sq_valid [SqrtSteps+1];
  logic [WideW-1:0] sq_rem   [SqrtSteps+1];
  logic [WideW-1:0] sq_root  [SqrtSteps+1];
  logic [WorkW-1:0] sq_tag   [SqrtSteps+1];

  assign sq_valid[0] = s1_valid_q;
  assign sq_rem[0]   = s1_n_q;
  assign sq_root[0]  = '0;
  assign sq_tag[0]   = s1_work_q;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    pfj_sqrt_cell #(
      .STEP  (i),
      .TAG_W (WorkW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .tag_i   (sq_tag[i]),
      .valid_o (sq_valid[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .tag_o   (sq_tag[i+1])
    );
  end

  // ---------------- Stage 2: scaled dividends for the unit vector ----------------
  work_t            sq_work;
  logic             s2_valid_q;
  work_t            s2_work_q;
  logic [DataW-1:0] s2_mag_q;
  logic [URemW-1:0] s2_rem_re_q, s2_rem_im_q;

  assign sq_work = work_t'(sq_tag[SqrtSteps]);

  // ---------------- Unit vector divider ----------------
  logic             ud_valid  [UQuoW+1];
  logic [DataW-1:0] ud_div    [UQuoW+1];
  logic [URemW-1:0] ud_rem_re [UQuoW+1];
  logic [URemW-1:0] ud_rem_im [UQuoW+1];
  logic [UQuoW-1:0] ud_q_re   [UQuoW+1];
  logic [UQuoW-1:0] ud_q_im   [UQuoW+1];
  logic [WorkW-1:0] ud_tag    [UQuoW+1];

  assign ud_valid[0]  = s2_valid_q;
  assign ud_div[0]    = s2_mag_q;
  assign ud_rem_re[0] = s2_rem_re_q;
  assign ud_rem_im[0] = s2_rem_im_q;
  assign ud_q_re[0]   = '0;
  assign ud_q_im[0]   = '0;
  assign ud_tag[0]    = s2_work_q;

  for (genvar i = 0; i < UQuoW; i++) begin : g_udiv
    pfj_div_cell #(
      .STEP  (UQuoW - 1 - i),
      .REM_W (URemW),
      .QW    (UQuoW),
      .TAG_W (WorkW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (ud_valid[i]),
      .div_i    (ud_div[i]),
      .rem_re_i (ud_rem_re[i]),
      .rem_im_i (ud_rem_im[i]),
      .q_re_i   (ud_q_re[i]),
      .q_im_i   (ud_q_im[i]),
      .tag_i    (ud_tag[i]),
      .valid_o  (ud_valid[i+1]),
      .div_o    (ud_div[i+1]),
      .rem_re_o (ud_rem_re[i+1]),
      .rem_im_o (ud_rem_im[i+1]),
      .q_re_o   (ud_q_re[i+1]),
      .q_im_o   (ud_q_im[i+1]),
      .tag_o    (ud_tag[i+1])
    );
  end

  // ---------------- Stage 3: signed unit vector, conj(S_i) ----------------
  work_t      ud_work;
  logic       ud_mz;
  word_t      uq_re, uq_im;
  sat_t       csi;
  logic       s3_valid_q;
  work_t      s3_work_q;
  logic [DataW-1:0] s3_mag_q;
  logic       s3_mz_q;
  word_t      s3_u_re_q, s3_u_im_q, s3_csi_im_q;
  logic       s3_csi_ov_q;

  always_comb begin
    ud_work = work_t'(ud_tag[UQuoW]);
    ud_mz   = ud_div[UQuoW] == '0;
    uq_re   = word_t'(ud_q_re[UQuoW]);
    uq_im   = word_t'(ud_q_im[UQuoW]);
    csi     = sat_word(-SatW'(ud_work.si_im));
  end

  // ---------------- Layer 1 products: A = Y*Vs, C = Y*u, Q = conj(S)*u ----------------
  word_t a_re, a_im, c_re, c_im, qp_re, qp_im;
  logic  a_ov, c_ov, qp_ov;

  pfj_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
    .clk_i (clk_i), .en_i (en),
    .a_re_i (s3_work_q.y_re), .a_im_i (s3_work_q.y_im),
    .b_re_i (s3_work_q.vs_re), .b_im_i (s3_work_q.vs_im),
    .re_o (a_re), .im_o (a_im), .ov_o (a_ov)
  );

  pfj_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c (
    .clk_i (clk_i), .en_i (en),
    .a_re_i (s3_work_q.y_re), .a_im_i (s3_work_q.y_im),
    .b_re_i (s3_u_re_q), .b_im_i (s3_u_im_q),
    .re_o (c_re), .im_o (c_im), .ov_o (c_ov)
  );

  pfj_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_q (
    .clk_i (clk_i), .en_i (en),
    .a_re_i (s3_work_q.si_re), .a_im_i (s3_csi_im_q),
    .b_re_i (s3_u_re_q), .b_im_i (s3_u_im_q),
    .re_o (qp_re), .im_o (qp_im), .ov_o (qp_ov)
  );

  // Align side data with the two multiplier stages
  logic             s4_valid_q, s5_valid_q;
  work_t            s4_work_q, s5_work_q;
  logic [DataW-1:0] s4_mag_q, s5_mag_q;
  logic             s4_mz_q, s5_mz_q;
  word_t            s4_u_re_q, s4_u_im_q, s5_u_re_q, s5_u_im_q;
  logic             s4_csi_ov_q, s5_csi_ov_q;

  // ---------------- Stage 6: conjugates of A and C ----------------
  sat_t             ca_im, cc_im;
  logic             s6_valid_q;
  work_t            s6_work_q;
  logic [DataW-1:0] s6_mag_q;
  logic             s6_mz_q;
  word_t            s6_u_re_q, s6_u_im_q;
  word_t            s6_ca_re_q, s6_ca_im_q, s6_cc_re_q, s6_cc_im_q, s6_q_re_q, s6_q_im_q;
  logic             s6_ov_common_q, s6_ov_extra_q;

  assign ca_im = sat_word(-SatW'(a_im));
  assign cc_im = sat_word(-SatW'(c_im));

  // ---------------- Layer 2 products: B = Vi*conj(A), E = Vi*conj(C), R = Q*u ----------------
  word_t b_re, b_im, e_re, e_im, r_re, r_im;
  logic  b_ov, e_ov, r_ov;

  pfj_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
    .clk_i (clk_i), .en_i (en),
    .a_re_i (s6_work_q.vi_re), .a_im_i (s6_work_q.vi_im),
    .b_re_i (s6_ca_re_q), .b_im_i (s6_ca_im_q),
    .re_o (b_re), .im_o (b_im), .ov_o (b_ov)
  );

  pfj_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
    .clk_i (clk_i), .en_i (en),
    .a_re_i (s6_work_q.vi_re), .a_im_i (s6_work_q.vi_im),
    .b_re_i (s6_cc_re_q), .b_im_i (s6_cc_im_q),
    .re_o (e_re), .im_o (e_im), .ov_o (e_ov)
  );

  pfj_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_r (
    .clk_i (clk_i), .en_i (en),
    .a_re_i (s6_q_re_q), .a_im_i (s6_q_im_q),
    .b_re_i (s6_u_re_q), .b_im_i (s6_u_im_q),
    .re_o (r_re), .im_o (r_im), .ov_o (r_ov)
  );

  logic             s7_valid_q, s8_valid_q;
  work_t            s7_work_q, s8_work_q;
  logic [DataW-1:0] s7_mag_q, s8_mag_q;
  logic             s7_mz_q, s8_mz_q;
  logic             s7_ov_common_q, s8_ov_common_q, s7_ov_extra_q, s8_ov_extra_q;

  // ---------------- Stage 9: quotient dividends and range check ----------------
  logic [TRemW-1:0] nr_re, nr_im;
  fin_t             fin_in;
  logic             s9_valid_q;
  logic [DataW-1:0] s9_mag_q;
  logic [TRemW-1:0] s9_rem_re_q, s9_rem_im_q;
  fin_t             s9_fin_q;

  always_comb begin
    nr_re            = TRemW'(abs_word(r_re)) << FRAC_BITS;
    nr_im            = TRemW'(abs_word(r_im)) << FRAC_BITS;
    fin_in.b_re      = b_re;
    fin_in.b_im      = b_im;
    fin_in.e_re      = e_re;
    fin_in.e_im      = e_im;
    fin_in.si_re     = s8_work_q.si_re;
    fin_in.si_im     = s8_work_q.si_im;
    fin_in.diag      = s8_work_q.diag;
    fin_in.mag_zero  = s8_mz_q;
    fin_in.ov_common = s8_ov_common_q | b_ov | e_ov;
    fin_in.ov_extra  = s8_ov_extra_q | r_ov;
    fin_in.sgn_re    = r_re[DataW-1];
    fin_in.sgn_im    = r_im[DataW-1];
    // a quotient of 2^32 or more can only clamp
    fin_in.tov_re    = nr_re[TRemW-1:TQuoW] >= s8_mag_q;
    fin_in.tov_im    = nr_im[TRemW-1:TQuoW] >= s8_mag_q;
  end

  // ---------------- Quotient divider: R * 2^F / |Vs| ----------------
  logic             td_valid  [TQuoW+1];
  logic [DataW-1:0] td_div    [TQuoW+1];
  logic [TRemW-1:0] td_rem_re [TQuoW+1];
  logic [TRemW-1:0] td_rem_im [TQuoW+1];
  logic [TQuoW-1:0] td_q_re   [TQuoW+1];
  logic [TQuoW-1:0] td_q_im   [TQuoW+1];
  logic [FinW-1:0]  td_tag    [TQuoW+1];

  assign td_valid[0]  = s9_valid_q;
  assign td_div[0]    = s9_mag_q;
  assign td_rem_re[0] = s9_rem_re_q;
  assign td_rem_im[0] = s9_rem_im_q;
  assign td_q_re[0]   = '0;
  assign td_q_im[0]   = '0;
  assign td_tag[0]    = s9_fin_q;

  for (genvar i = 0; i < TQuoW; i++) begin : g_tdiv
    pfj_div_cell #(
      .STEP  (TQuoW - 1 - i),
      .REM_W (TRemW),
      .QW    (TQuoW),
      .TAG_W (FinW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (td_valid[i]),
      .div_i    (td_div[i]),
      .rem_re_i (td_rem_re[i]),
      .rem_im_i (td_rem_im[i]),
      .q_re_i   (td_q_re[i]),
      .q_im_i   (td_q_im[i]),
      .tag_i    (td_tag[i]),
      .valid_o  (td_valid[i+1]),
      .div_o    (td_div[i+1]),
      .rem_re_o (td_rem_re[i+1]),
      .rem_im_o (td_rem_im[i+1]),
      .q_re_o   (td_q_re[i+1]),
      .q_im_o   (td_q_im[i+1]),
      .tag_o    (td_tag[i+1])
    );
  end

  assign fin_valid = td_valid[TQuoW];

  // ---------------- Final combine ----------------
  fin_t  fin;
  sat_t  t_re, t_im, d_re, d_im, dth_re, dv_re, dv_im, nb_re;
  word_t tv_re, tv_im;

  always_comb begin
    fin  = fin_t'(td_tag[TQuoW]);
    t_re = sat_word(fin.sgn_re ? -$signed(SatW'(td_q_re[TQuoW]))
                               : $signed(SatW'(td_q_re[TQuoW])));
    t_im = sat_word(fin.sgn_im ? -$signed(SatW'(td_q_im[TQuoW]))
                               : $signed(SatW'(td_q_im[TQuoW])));
    if (fin.tov_re) begin
      t_re.v  = fin.sgn_re ? WordMin : WordMax;
      t_re.ov = 1'b1;
    end
    if (fin.tov_im) begin
      t_im.v  = fin.sgn_im ? WordMin : WordMax;
      t_im.ov = 1'b1;
    end
    // zero row voltage drops the quotient term
    tv_re  = fin.mag_zero ? '0 : t_re.v;
    tv_im  = fin.mag_zero ? '0 : t_im.v;
    d_re   = sat_word(SatW'(fin.si_re) - SatW'(fin.b_re));
    d_im   = sat_word(SatW'(fin.si_im) - SatW'(fin.b_im));
    dth_re = sat_word(-SatW'(d_im.v));
    dv_re  = sat_word(SatW'(tv_re) + SatW'(fin.e_re));
    dv_im  = sat_word(SatW'(tv_im) + SatW'(fin.e_im));
    nb_re  = sat_word(-SatW'(fin.b_re));
    if (fin.diag) begin
      res.dp_dtheta = dth_re.v;
      res.dq_dtheta = d_re.v;
      res.dp_dvmag  = dv_re.v;
      res.dq_dvmag  = dv_im.v;
      res.fault     = fin.ov_common | d_re.ov | d_im.ov | dth_re.ov | dv_re.ov | dv_im.ov |
                      (fin.mag_zero ? 1'b1 : (fin.ov_extra | t_re.ov | t_im.ov));
    end else begin
      res.dp_dtheta = fin.b_im;
      res.dq_dtheta = nb_re.v;
      res.dp_dvmag  = fin.e_re;
      res.dq_dvmag  = fin.e_im;
      res.fault     = fin.ov_common | nb_re.ov;
    end
  end

  // ---------------- Valid chain of the plain stages ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_i.valid;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= sq_valid[SqrtSteps];
      s3_valid_q <= ud_valid[UQuoW];
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
      s9_valid_q <= s8_valid_q;
    end
  end

  // ---------------- Data of the plain stages ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_work_q      <= w_in;
      s0_sqre_q      <= w_in.vs_re * w_in.vs_re;
      s0_sqim_q      <= w_in.vs_im * w_in.vs_im;

      s1_work_q      <= s0_work_q;
      s1_n_q         <= $unsigned(s0_sqre_q) + $unsigned(s0_sqim_q);

      s2_work_q      <= sq_work;
      s2_mag_q       <= sq_root[SqrtSteps][DataW-1:0];
      s2_rem_re_q    <= URemW'(abs_word(sq_work.vs_re)) << FRAC_BITS;
      s2_rem_im_q    <= URemW'(abs_word(sq_work.vs_im)) << FRAC_BITS;

      s3_work_q      <= ud_work;
      s3_mag_q       <= ud_div[UQuoW];
      s3_mz_q        <= ud_mz;
      s3_u_re_q      <= ud_mz ? '0 : (ud_work.vs_re[DataW-1] ? -uq_re : uq_re);
      s3_u_im_q      <= ud_mz ? '0 : (ud_work.vs_im[DataW-1] ? -uq_im : uq_im);
      s3_csi_im_q    <= csi.v;
      s3_csi_ov_q    <= csi.ov;

      s4_work_q      <= s3_work_q;
      s4_mag_q       <= s3_mag_q;
      s4_mz_q        <= s3_mz_q;
      s4_u_re_q      <= s3_u_re_q;
      s4_u_im_q      <= s3_u_im_q;
      s4_csi_ov_q    <= s3_csi_ov_q;

      s5_work_q      <= s4_work_q;
      s5_mag_q       <= s4_mag_q;
      s5_mz_q        <= s4_mz_q;
      s5_u_re_q      <= s4_u_re_q;
      s5_u_im_q      <= s4_u_im_q;
      s5_csi_ov_q    <= s4_csi_ov_q;

      s6_work_q      <= s5_work_q;
      s6_mag_q       <= s5_mag_q;
      s6_mz_q        <= s5_mz_q;
      s6_u_re_q      <= s5_u_re_q;
      s6_u_im_q      <= s5_u_im_q;
      s6_ca_re_q     <= a_re;
      s6_ca_im_q     <= ca_im.v;
      s6_cc_re_q     <= c_re;
      s6_cc_im_q     <= cc_im.v;
      s6_q_re_q      <= qp_re;
      s6_q_im_q      <= qp_im;
      s6_ov_common_q <= a_ov | ca_im.ov | c_ov | cc_im.ov;
      s6_ov_extra_q  <= s5_csi_ov_q | qp_ov;

      s7_work_q      <= s6_work_q;
      s7_mag_q       <= s6_mag_q;
      s7_mz_q        <= s6_mz_q;
      s7_ov_common_q <= s6_ov_common_q;
      s7_ov_extra_q  <= s6_ov_extra_q;

      s8_work_q      <= s7_work_q;
      s8_mag_q       <= s7_mag_q;
      s8_mz_q        <= s7_mz_q;
      s8_ov_common_q <= s7_ov_common_q;
      s8_ov_extra_q  <= s7_ov_extra_q;

      s9_mag_q       <= s8_mag_q;
      s9_rem_re_q    <= nr_re;
      s9_rem_im_q    <= nr_im;
      s9_fin_q       <= fin_in;
    end
  end

  // ---------------- Output register: hold until the transaction completes ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
